@@ hdl/bcsh_pkg.sv @@
// Shared constants, register codes and settings struct for the color adjust block
`default_nettype none

package bcsh_pkg;

    // Pixel and fixed-point format
    localparam int PIX_W       = 10;
    localparam int FRAC_BITS   = 11;
    localparam int CAP_W       = PIX_W + FRAC_BITS;
    localparam int CH          = 3;

    // Register widths
    localparam int GAIN_W      = 14;
    localparam int BRI_W       = 13;
    localparam int WGT_W       = 17;
    localparam int ANG_W       = 16;
    localparam int CFG_W       = WGT_W;
    localparam int IDX_W       = 3;

    // Derived setting widths
    localparam int OFF_W       = PIX_W + BRI_W + 1;
    localparam int K0_W        = GAIN_W + 1;
    localparam int KC_W        = ANG_W + 1;

    // Datapath widths
    localparam int BSUM_W      = OFF_W + 1;
    localparam int PROD_W      = CAP_W + GAIN_W;
    localparam int LUMA_PROD_W = CAP_W + WGT_W;
    localparam int LSUM_W      = LUMA_PROD_W + 2;
    localparam int A_W         = PROD_W + 1 - FRAC_BITS;
    localparam int KG_W        = K0_W + CAP_W + 1;
    localparam int MIX_W       = KG_W + 1 - FRAC_BITS;
    localparam int SUM_W       = MIX_W + 2;
    localparam int D_W         = MIX_W + 1;
    localparam int M1_W        = SUM_W + KC_W;
    localparam int M2_W        = ANG_W + D_W;
    localparam int M3_W        = ANG_W + MIX_W;
    localparam int LUMA_SHIFT  = 16;
    localparam int HUE_SHIFT   = 30;
    localparam int ACC_W       = 62;
    localparam int HUE_W       = ACC_W - HUE_SHIFT;

    // Pipeline depth
    localparam int STAGES       = 12;
    localparam int LANE_STAGES  = 5;
    localparam int MERGE_STAGES = STAGES - LANE_STAGES;

    // Limits
    localparam logic [GAIN_W-1:0]       GAIN_MAX  = GAIN_W'(4 << FRAC_BITS);
    localparam logic signed [BRI_W-1:0] BRI_MAX   = BRI_W'(1 << FRAC_BITS);
    localparam logic signed [BRI_W-1:0] BRI_MIN   = -BRI_W'(1 << FRAC_BITS);
    localparam logic [WGT_W-1:0]        LUMA_ONE  = WGT_W'(65536);
    localparam logic signed [ANG_W-1:0] ANG_MAX   = ANG_W'(16384);
    localparam logic signed [ANG_W-1:0] ANG_MIN   = -ANG_W'(16384);
    localparam logic signed [KC_W-1:0]  ANG_ONE   = KC_W'(16384);
    localparam logic signed [K0_W-1:0]  GAIN_ONE  = K0_W'(1 << FRAC_BITS);

    // Rotation constants, Q16
    localparam logic signed [ACC_W-1:0] THIRD_Q16     = ACC_W'(21845);
    localparam logic signed [ACC_W-1:0] INV_SQRT3_Q16 = ACC_W'(37837);
    localparam logic signed [ACC_W-1:0] HUE_HALF      = ACC_W'(64'd1 << (HUE_SHIFT - 1));

    // Register reset values
    localparam logic [PIX_W-1:0]        RST_MAX_VALUE  = PIX_W'(1023);
    localparam logic [GAIN_W-1:0]       RST_CONTRAST   = GAIN_W'(2048);
    localparam logic signed [BRI_W-1:0] RST_BRIGHTNESS = '0;
    localparam logic [GAIN_W-1:0]       RST_SATURATION = GAIN_W'(2048);
    localparam logic [WGT_W-1:0]        RST_LUMA_RED   = WGT_W'(13933);
    localparam logic [WGT_W-1:0]        RST_LUMA_GREEN = WGT_W'(46871);
    localparam logic signed [ANG_W-1:0] RST_HUE_COS    = ANG_W'(16384);
    localparam logic signed [ANG_W-1:0] RST_HUE_SIN    = '0;

    // Register map
    typedef enum logic [IDX_W-1:0] {
        REG_MAX_VALUE         = 3'd0,
        REG_CONTRAST_GAIN     = 3'd1,
        REG_BRIGHTNESS_OFFSET = 3'd2,
        REG_SATURATION_SCALE  = 3'd3,
        REG_LUMA_WEIGHT_RED   = 3'd4,
        REG_LUMA_WEIGHT_GREEN = 3'd5,
        REG_HUE_COSINE        = 3'd6,
        REG_HUE_SINE          = 3'd7
    } cfg_idx_t;

    // Clamped and precomputed settings seen by the datapath
    typedef struct packed {
        logic [PIX_W-1:0]        maxv;
        logic [CAP_W-1:0]        cap;
        logic signed [OFF_W-1:0] off;
        logic [GAIN_W-1:0]       gc;
        logic [GAIN_W-1:0]       sc;
        logic signed [K0_W-1:0]  k0;
        logic [WGT_W-1:0]        wr;
        logic [WGT_W-1:0]        wg;
        logic [WGT_W-1:0]        wb;
        logic signed [ANG_W-1:0] cs;
        logic signed [ANG_W-1:0] sn;
        logic signed [KC_W-1:0]  kc;
        logic                    bypass;
    } bcsh_cfg_t;

endpackage

`default_nettype wire

@@ hdl/bcsh_in_if.sv @@
// Input pixel channel: valid/ready handshake with RGB payload
`default_nettype none

interface bcsh_in_if import bcsh_pkg::*;;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] red_in;
    logic [PIX_W-1:0] green_in;
    logic [PIX_W-1:0] blue_in;

    modport source (output valid, output red_in, output green_in, output blue_in,
                    input ready);
    modport sink   (input valid, input red_in, input green_in, input blue_in,
                    output ready);

endinterface

`default_nettype wire

@@ hdl/bcsh_out_if.sv @@
// Output pixel channel: valid/ready handshake with RGB payload
`default_nettype none

interface bcsh_out_if import bcsh_pkg::*;;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] red_out;
    logic [PIX_W-1:0] green_out;
    logic [PIX_W-1:0] blue_out;

    modport source (output valid, output red_out, output green_out, output blue_out,
                    input ready);
    modport sink   (input valid, input red_out, input green_out, input blue_out,
                    output ready);

endinterface

`default_nettype wire

@@ hdl/bcsh_cfg.sv @@
// Configuration registers and the registered, clamped settings derived from them
`default_nettype none

module bcsh_cfg
    import bcsh_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    output bcsh_cfg_t        cfg
);

    logic [PIX_W-1:0]        max_value_reg;
    logic [GAIN_W-1:0]       contrast_gain_reg;
    logic signed [BRI_W-1:0] brightness_offset_reg;
    logic [GAIN_W-1:0]       saturation_scale_reg;
    logic [WGT_W-1:0]        luma_red_reg;
    logic [WGT_W-1:0]        luma_green_reg;
    logic signed [ANG_W-1:0] hue_cos_reg;
    logic signed [ANG_W-1:0] hue_sin_reg;

    bcsh_cfg_t cfg_reg, cfg_next;

    logic signed [BRI_W-1:0] db;
    logic [GAIN_W-1:0]       sc_c;
    logic [WGT_W-1:0]        wr_c;
    logic [WGT_W-1:0]        wg_c;
    logic [WGT_W-1:0]        rem;
    logic signed [ANG_W-1:0] cs_c;
    logic signed [ANG_W-1:0] sn_c;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_value_reg         <= RST_MAX_VALUE;
            contrast_gain_reg     <= RST_CONTRAST;
            brightness_offset_reg <= RST_BRIGHTNESS;
            saturation_scale_reg  <= RST_SATURATION;
            luma_red_reg          <= RST_LUMA_RED;
            luma_green_reg        <= RST_LUMA_GREEN;
            hue_cos_reg           <= RST_HUE_COS;
            hue_sin_reg           <= RST_HUE_SIN;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                REG_MAX_VALUE:         max_value_reg         <= cfg_data[PIX_W-1:0];
                REG_CONTRAST_GAIN:     contrast_gain_reg     <= cfg_data[GAIN_W-1:0];
                REG_BRIGHTNESS_OFFSET: brightness_offset_reg <= cfg_data[BRI_W-1:0];
                REG_SATURATION_SCALE:  saturation_scale_reg  <= cfg_data[GAIN_W-1:0];
                REG_LUMA_WEIGHT_RED:   luma_red_reg          <= cfg_data[WGT_W-1:0];
                REG_LUMA_WEIGHT_GREEN: luma_green_reg        <= cfg_data[WGT_W-1:0];
                REG_HUE_COSINE:        hue_cos_reg           <= cfg_data[ANG_W-1:0];
                REG_HUE_SINE:          hue_sin_reg           <= cfg_data[ANG_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp settings and precompute offset, gray mix and rotation terms
    always_comb
    begin
        if (brightness_offset_reg > BRI_MAX)
            db = BRI_MAX;
        else if (brightness_offset_reg < BRI_MIN)
            db = BRI_MIN;
        else
            db = brightness_offset_reg;

        sc_c = (saturation_scale_reg > GAIN_MAX) ? GAIN_MAX : saturation_scale_reg;
        wr_c = (luma_red_reg > LUMA_ONE) ? LUMA_ONE : luma_red_reg;
        rem  = LUMA_ONE - wr_c;
        wg_c = (luma_green_reg > rem) ? rem : luma_green_reg;

        if (hue_cos_reg > ANG_MAX)
            cs_c = ANG_MAX;
        else if (hue_cos_reg < ANG_MIN)
            cs_c = ANG_MIN;
        else
            cs_c = hue_cos_reg;

        if (hue_sin_reg > ANG_MAX)
            sn_c = ANG_MAX;
        else if (hue_sin_reg < ANG_MIN)
            sn_c = ANG_MIN;
        else
            sn_c = hue_sin_reg;

        cfg_next.maxv   = max_value_reg;
        cfg_next.cap    = {max_value_reg, {FRAC_BITS{1'b0}}};
        cfg_next.off    = OFF_W'(db) * OFF_W'($signed({1'b0, max_value_reg}));
        cfg_next.gc     = (contrast_gain_reg > GAIN_MAX) ? GAIN_MAX : contrast_gain_reg;
        cfg_next.sc     = sc_c;
        cfg_next.k0     = GAIN_ONE - $signed({1'b0, sc_c});
        cfg_next.wr     = wr_c;
        cfg_next.wg     = wg_c;
        cfg_next.wb     = rem - wg_c;
        cfg_next.cs     = cs_c;
        cfg_next.sn     = sn_c;
        cfg_next.kc     = ANG_ONE - KC_W'(cs_c);
        cfg_next.bypass = (cs_c == ANG_MAX) && (sn_c == '0);
    end

    // Settings register, takes up the writes on the next clock
    always_ff @(posedge clk)
    begin
        cfg_reg <= cfg_next;
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

@@ hdl/bcsh_lane.sv @@
// Per-channel front end: brightness, contrast, luma and saturation products
`default_nettype none

module bcsh_lane
    import bcsh_pkg::*;
(
    input  logic                   clk,
    input  logic [LANE_STAGES-1:0] en,
    input  logic [PIX_W-1:0]       pix,
    input  bcsh_cfg_t              cfg,
    input  logic [WGT_W-1:0]       weight,
    output logic [LUMA_PROD_W-1:0] luma,
    output logic [PROD_W-1:0]      sat
);

    localparam logic [PROD_W:0] Q_HALF = (PROD_W+1)'(1 << (FRAC_BITS - 1));

    logic [PIX_W-1:0]       pix_reg;
    logic [CAP_W-1:0]       bri_reg, bri_next;
    logic [PROD_W-1:0]      gain_reg;
    logic [CAP_W-1:0]       con_reg, con_next;
    logic [LUMA_PROD_W-1:0] luma_reg;
    logic [PROD_W-1:0]      sat_reg;

    logic signed [OFF_W-1:0]  off_s;
    logic signed [BSUM_W-1:0] bsum;
    logic signed [BSUM_W-1:0] cap_s;
    logic [PROD_W:0]          gain_rnd;
    logic [PROD_W:0]          gain_q;

    assign off_s = cfg.off;
    assign cap_s = $signed({{(BSUM_W-CAP_W){1'b0}}, cfg.cap});

    // Brightness offset, clamp to [0, cap]
    always_comb
    begin
        bsum = $signed({{(BSUM_W-CAP_W){1'b0}}, pix_reg, {FRAC_BITS{1'b0}}})
             + BSUM_W'(off_s);
        if (bsum < 0)
            bri_next = '0;
        else if (bsum > cap_s)
            bri_next = cfg.cap;
        else
            bri_next = bsum[CAP_W-1:0];
    end

    // Contrast product rounded back to Q11, clamp to cap
    always_comb
    begin
        gain_rnd = {1'b0, gain_reg} + Q_HALF;
        gain_q   = gain_rnd >> FRAC_BITS;
        if (gain_q > (PROD_W+1)'(cfg.cap))
            con_next = cfg.cap;
        else
            con_next = gain_q[CAP_W-1:0];
    end

    // Stage registers
    always_ff @(posedge clk)
    begin
        if (en[0])
            pix_reg <= pix;
        if (en[1])
            bri_reg <= bri_next;
        if (en[2])
            gain_reg <= bri_reg * cfg.gc;
        if (en[3])
            con_reg <= con_next;
        if (en[4])
        begin
            luma_reg <= con_reg * weight;
            sat_reg  <= cfg.sc * con_reg;
        end
    end

    assign luma = luma_reg;
    assign sat  = sat_reg;

endmodule

`default_nettype wire

@@ hdl/bcsh_merge.sv @@
// Merge stage: luma gray, saturation mix, hue rotation and final rounding
`default_nettype none

module bcsh_merge
    import bcsh_pkg::*;
(
    input  logic                             clk,
    input  logic [MERGE_STAGES-1:0]          en,
    input  bcsh_cfg_t                        cfg,
    input  logic [CH-1:0][LUMA_PROD_W-1:0]   luma,
    input  logic [CH-1:0][PROD_W-1:0]        sat,
    output logic [CH-1:0][PIX_W-1:0]         pix
);

    localparam logic [LSUM_W-1:0]       L_HALF  = LSUM_W'(1 << (LUMA_SHIFT - 1));
    localparam logic [PROD_W:0]         Q_HALF  = (PROD_W+1)'(1 << (FRAC_BITS - 1));
    localparam logic signed [KG_W:0]    KG_HALF = (KG_W+1)'(1 << (FRAC_BITS - 1));
    localparam logic signed [HUE_W:0]   H_HALF  = (HUE_W+1)'(1 << (FRAC_BITS - 1));

    // Stage registers
    logic [CAP_W-1:0]        gray_reg;
    logic [PROD_W-1:0]       sat_reg [CH];
    logic signed [KG_W-1:0]  kg_reg;
    logic [A_W-1:0]          a_reg [CH];
    logic signed [MIX_W-1:0] mix_reg [CH];
    logic signed [M1_W-1:0]  m1_reg;
    logic signed [M2_W-1:0]  m2_reg [CH];
    logic signed [M3_W-1:0]  m3_reg [CH];
    logic signed [MIX_W-1:0] hold_reg [CH];
    logic signed [ACC_W-1:0] hsum_reg;
    logic signed [ACC_W-1:0] hrot_reg [CH];
    logic signed [M3_W-1:0]  hcos_reg [CH];
    logic signed [MIX_W-1:0] hold2_reg [CH];
    logic signed [HUE_W-1:0] hue_reg [CH];
    logic [PIX_W-1:0]        pix_reg [CH];

    // Next values
    logic [CAP_W-1:0]        gray_next;
    logic signed [KG_W-1:0]  kg_next;
    logic [A_W-1:0]          a_next [CH];
    logic signed [MIX_W-1:0] mix_next [CH];
    logic signed [M1_W-1:0]  m1_next;
    logic signed [M2_W-1:0]  m2_next [CH];
    logic signed [M3_W-1:0]  m3_next [CH];
    logic signed [HUE_W-1:0] hue_next [CH];
    logic [PIX_W-1:0]        pix_next [CH];

    logic [LSUM_W-1:0]       lsum;
    logic [LSUM_W-1:0]       gray_full;
    logic signed [K0_W-1:0]  k0_s;
    logic signed [KC_W-1:0]  kc_s;
    logic signed [ANG_W-1:0] cs_s;
    logic signed [ANG_W-1:0] sn_s;
    logic signed [KG_W:0]    kg_rnd;
    logic signed [SUM_W-1:0] ssum;

    assign k0_s = cfg.k0;
    assign kc_s = cfg.kc;
    assign cs_s = cfg.cs;
    assign sn_s = cfg.sn;

    // Luma gray, rounded half up from Q16 weights
    always_comb
    begin
        lsum = LSUM_W'(luma[0]) + LSUM_W'(luma[1]) + LSUM_W'(luma[2]) + L_HALF;
        gray_full = lsum >> LUMA_SHIFT;
        gray_next = gray_full[CAP_W-1:0];
    end

    // Gray term product and rounded saturation products
    always_comb
    begin
        logic [PROD_W:0] srnd;
        logic [PROD_W:0] sq;
        kg_next = KG_W'(k0_s) * KG_W'($signed({1'b0, gray_reg}));
        for (int i = 0; i < CH; i++)
        begin
            srnd      = {1'b0, sat_reg[i]} + Q_HALF;
            sq        = srnd >> FRAC_BITS;
            a_next[i] = sq[A_W-1:0];
        end
    end

    // Saturation mix
    always_comb
    begin
        kg_rnd = (KG_W+1)'(kg_reg) + KG_HALF;
        for (int i = 0; i < CH; i++)
            mix_next[i] = MIX_W'($signed({1'b0, a_reg[i]})) + MIX_W'(kg_rnd >>> FRAC_BITS);
    end

    // Rotation partial products: gray-axis term, cross terms, direct terms
    always_comb
    begin
        ssum    = SUM_W'(mix_reg[0]) + SUM_W'(mix_reg[1]) + SUM_W'(mix_reg[2]);
        m1_next = M1_W'(ssum) * M1_W'(kc_s);
        m2_next[0] = M2_W'(sn_s) * M2_W'(D_W'(mix_reg[2]) - D_W'(mix_reg[1]));
        m2_next[1] = M2_W'(sn_s) * M2_W'(D_W'(mix_reg[0]) - D_W'(mix_reg[2]));
        m2_next[2] = M2_W'(sn_s) * M2_W'(D_W'(mix_reg[1]) - D_W'(mix_reg[0]));
        for (int i = 0; i < CH; i++)
            m3_next[i] = M3_W'(cs_s) * M3_W'(mix_reg[i]);
    end

    // Accumulate Q30, round back to Q11, or pass through when rotation is off
    always_comb
    begin
        logic signed [ACC_W-1:0] acc;
        for (int i = 0; i < CH; i++)
        begin
            acc = (ACC_W'(hcos_reg[i]) <<< LUMA_SHIFT) + hsum_reg + hrot_reg[i] + HUE_HALF;
            if (cfg.bypass)
                hue_next[i] = HUE_W'(hold2_reg[i]);
            else
                hue_next[i] = HUE_W'(acc >>> HUE_SHIFT);
        end
    end

    // Final rounding to pixel units and clamp to [0, max]
    always_comb
    begin
        logic signed [HUE_W:0] rv;
        logic signed [HUE_W:0] mv;
        mv = $signed({{(HUE_W+1-PIX_W){1'b0}}, cfg.maxv});
        for (int i = 0; i < CH; i++)
        begin
            rv = ((HUE_W+1)'(hue_reg[i]) + H_HALF) >>> FRAC_BITS;
            if (rv < 0)
                pix_next[i] = '0;
            else if (rv > mv)
                pix_next[i] = cfg.maxv;
            else
                pix_next[i] = rv[PIX_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            gray_reg <= gray_next;
            for (int i = 0; i < CH; i++)
                sat_reg[i] <= sat[i];
        end
        if (en[1])
        begin
            kg_reg <= kg_next;
            for (int i = 0; i < CH; i++)
                a_reg[i] <= a_next[i];
        end
        if (en[2])
        begin
            for (int i = 0; i < CH; i++)
                mix_reg[i] <= mix_next[i];
        end
        if (en[3])
        begin
            m1_reg <= m1_next;
            for (int i = 0; i < CH; i++)
            begin
                m2_reg[i]   <= m2_next[i];
                m3_reg[i]   <= m3_next[i];
                hold_reg[i] <= mix_reg[i];
            end
        end
        if (en[4])
        begin
            hsum_reg <= ACC_W'(m1_reg) * THIRD_Q16;
            for (int i = 0; i < CH; i++)
            begin
                hrot_reg[i]  <= ACC_W'(m2_reg[i]) * INV_SQRT3_Q16;
                hcos_reg[i]  <= m3_reg[i];
                hold2_reg[i] <= hold_reg[i];
            end
        end
        if (en[5])
        begin
            for (int i = 0; i < CH; i++)
                hue_reg[i] <= hue_next[i];
        end
        if (en[6])
        begin
            for (int i = 0; i < CH; i++)
                pix_reg[i] <= pix_next[i];
        end
    end

    always_comb
    begin
        for (int i = 0; i < CH; i++)
            pix[i] = pix_reg[i];
    end

endmodule

`default_nettype wire

@@ hdl/rgb_bcsh_color_adjust.sv @@
// Top level of the RGB brightness / contrast / saturation / hue adjust block
//
// Accepts one RGB pixel per clock while the pipeline has room and returns the adjusted pixel
// through a twelve-stage pipeline: three channel lanes of five stages, then a seven-stage
// merge that forms the luma gray, the saturation mix and the hue rotation.
// Each stage holds its item until the next stage has room, so bubbles close up and input
// is still taken while a finished pixel waits at the output. Register writes reach the
// datapath through a settings register; a pixel accepted after that register has taken up
// the last write sees the new values. No clearing pass is needed after reset.
`default_nettype none

module rgb_bcsh_color_adjust
    import bcsh_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    bcsh_in_if.sink          pix_in,
    bcsh_out_if.source       pix_out,
    input  logic             cfg_we,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    bcsh_cfg_t cfg;

    logic [STAGES-1:0] valid_reg, valid_next;
    logic [STAGES:0]   en;

    logic [CH-1:0][PIX_W-1:0]       pix_lane;
    logic [CH-1:0][WGT_W-1:0]       weight;
    logic [CH-1:0][LUMA_PROD_W-1:0] luma;
    logic [CH-1:0][PROD_W-1:0]      sat;
    logic [CH-1:0][PIX_W-1:0]       pix_res;

    logic in_acc;
    logic out_acc;

    // Stage k moves when it is empty or stage k+1 moves
    assign en[STAGES] = pix_out.ready;
    for (genvar k = 0; k < STAGES; k++)
    begin : g_en
        assign en[k] = !valid_reg[k] || en[k+1];
    end

    // Valid chain
    always_comb
    begin
        valid_next[0] = en[0] ? pix_in.valid : valid_reg[0];
        for (int k = 1; k < STAGES; k++)
            valid_next[k] = en[k] ? valid_reg[k-1] : valid_reg[k];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    assign pix_in.ready = en[0];
    assign in_acc  = pix_in.valid && pix_in.ready;
    assign out_acc = pix_out.valid && pix_out.ready;

    // Settings
    bcsh_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Channel lanes
    assign pix_lane[0] = pix_in.red_in;
    assign pix_lane[1] = pix_in.green_in;
    assign pix_lane[2] = pix_in.blue_in;
    assign weight[0]   = cfg.wr;
    assign weight[1]   = cfg.wg;
    assign weight[2]   = cfg.wb;

    for (genvar i = 0; i < CH; i++)
    begin : g_lane
        bcsh_lane u_lane (
            .clk    (clk),
            .en     (en[LANE_STAGES-1:0]),
            .pix    (pix_lane[i]),
            .cfg    (cfg),
            .weight (weight[i]),
            .luma   (luma[i]),
            .sat    (sat[i])
        );
    end

    // Merge
    bcsh_merge u_merge (
        .clk  (clk),
        .en   (en[STAGES-1:LANE_STAGES]),
        .cfg  (cfg),
        .luma (luma),
        .sat  (sat),
        .pix  (pix_res)
    );

    assign pix_out.valid     = valid_reg[STAGES-1];
    assign pix_out.red_out   = pix_res[0];
    assign pix_out.green_out = pix_res[1];
    assign pix_out.blue_out  = pix_res[2];

    // Item count in the pipe changes only by accepted inputs and delivered results
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> $countones(valid_reg) ==
                 $past($countones(valid_reg)) + $past(in_acc) - $past(out_acc))
        else $error("pipeline item count mismatch");

    // A full pipe with a stalled output takes no input
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (&valid_reg) && !pix_out.ready |-> !pix_in.ready)
        else $error("input taken while pipeline full and stalled");

    // An empty first stage always takes input
    a_head_free: assert property (@(posedge clk) disable iff (!rst_n)
        !valid_reg[0] |-> pix_in.ready)
        else $error("input refused with free first stage");

    // An accepted item lands in the first stage
    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> valid_reg[0])
        else $error("accepted item lost at pipeline entry");

endmodule

`default_nettype wire

@@ verif/bcsh_test_pkg.sv @@
// Pixel type and checker class for the color adjust testbench
package bcsh_test_pkg;

    import bcsh_pkg::*;

    localparam int     REG_COUNT   = 8;
    localparam int     MAX_REPORTS = 10;
    localparam longint FIX_ONE     = longint'(1) << FRAC_BITS;
    localparam longint LUMA_UNIT   = 65536;
    localparam longint ANGLE_UNIT  = 16384;
    localparam longint THIRD_Q16   = 21845;
    localparam longint RSQRT3_Q16  = 37837;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } pixel_t;

    // Predicts adjusted pixels from its own copy of the registers and checks the outputs
    class color_adjust_checker;

        logic [CFG_W-1:0] regs [REG_COUNT];
        pixel_t           expected_pixels [$];
        int unsigned      errors;

        function new();
            regs[REG_MAX_VALUE]         = CFG_W'(RST_MAX_VALUE);
            regs[REG_CONTRAST_GAIN]     = CFG_W'(RST_CONTRAST);
            regs[REG_BRIGHTNESS_OFFSET] = CFG_W'(RST_BRIGHTNESS);
            regs[REG_SATURATION_SCALE]  = CFG_W'(RST_SATURATION);
            regs[REG_LUMA_WEIGHT_RED]   = CFG_W'(RST_LUMA_RED);
            regs[REG_LUMA_WEIGHT_GREEN] = CFG_W'(RST_LUMA_GREEN);
            regs[REG_HUE_COSINE]        = CFG_W'(RST_HUE_COS);
            regs[REG_HUE_SINE]          = CFG_W'(RST_HUE_SIN);
            errors = 0;
        endfunction

        function void set_reg(cfg_idx_t idx, logic [CFG_W-1:0] value);
            regs[idx] = value;
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction

        static function longint clamp(longint v, longint lo, longint hi);
            return (v < lo) ? lo : ((v > hi) ? hi : v);
        endfunction

        // v / 2^s, rounded half toward plus infinity
        static function longint round_q(longint v, int s);
            return (v + (longint'(1) << (s - 1))) >>> s;
        endfunction

        function pixel_t adjusted_pixel(pixel_t px);
            logic signed [BRI_W-1:0] bri_raw;
            logic signed [ANG_W-1:0] cos_raw;
            logic signed [ANG_W-1:0] sin_raw;
            longint maxv, cap, gc, db, sc, wr, wg, wb, cs, sn, off, k0, gray, chsum, acc, x;
            longint q [3];
            longint d [3];
            pixel_t res;

            // registers as the datapath sees them, saturated to their legal ranges
            maxv    = regs[REG_MAX_VALUE][PIX_W-1:0];
            cap     = maxv * FIX_ONE;
            gc      = regs[REG_CONTRAST_GAIN][GAIN_W-1:0];
            gc      = clamp(gc, 0, 4 * FIX_ONE);
            bri_raw = regs[REG_BRIGHTNESS_OFFSET][BRI_W-1:0];
            db      = clamp(bri_raw, -FIX_ONE, FIX_ONE);
            sc      = regs[REG_SATURATION_SCALE][GAIN_W-1:0];
            sc      = clamp(sc, 0, 4 * FIX_ONE);
            wr      = regs[REG_LUMA_WEIGHT_RED][WGT_W-1:0];
            wr      = clamp(wr, 0, LUMA_UNIT);
            wg      = regs[REG_LUMA_WEIGHT_GREEN][WGT_W-1:0];
            wg      = clamp(wg, 0, LUMA_UNIT - wr);
            wb      = LUMA_UNIT - wr - wg;
            cos_raw = regs[REG_HUE_COSINE][ANG_W-1:0];
            sin_raw = regs[REG_HUE_SINE][ANG_W-1:0];
            cs      = clamp(cos_raw, -ANGLE_UNIT, ANGLE_UNIT);
            sn      = clamp(sin_raw, -ANGLE_UNIT, ANGLE_UNIT);
            off     = db * maxv;

            q[0] = px.red;
            q[1] = px.green;
            q[2] = px.blue;

            // brightness then contrast, each clamped to full scale
            for (int i = 0; i < 3; i++) begin
                x    = clamp(q[i] * FIX_ONE + off, 0, cap);
                q[i] = clamp(round_q(x * gc, FRAC_BITS), 0, cap);
            end

            // saturation: mix toward luma gray, unclamped
            gray = round_q(q[0] * wr + q[1] * wg + q[2] * wb, LUMA_SHIFT);
            k0   = FIX_ONE - sc;
            for (int i = 0; i < 3; i++)
                q[i] = round_q(sc * q[i], FRAC_BITS) + round_q(k0 * gray, FRAC_BITS);

            // hue rotation about the gray axis, skipped at zero angle
            if (!(cs == ANGLE_UNIT && sn == 0)) begin
                d[0]  = q[2] - q[1];
                d[1]  = q[0] - q[2];
                d[2]  = q[1] - q[0];
                chsum = (q[0] + q[1] + q[2]) * (ANGLE_UNIT - cs) * THIRD_Q16;
                for (int i = 0; i < 3; i++) begin
                    acc  = cs * q[i] * LUMA_UNIT + chsum + sn * d[i] * RSQRT3_Q16;
                    q[i] = round_q(acc, HUE_SHIFT);
                end
            end

            res.red   = PIX_W'(clamp(round_q(q[0], FRAC_BITS), 0, maxv));
            res.green = PIX_W'(clamp(round_q(q[1], FRAC_BITS), 0, maxv));
            res.blue  = PIX_W'(clamp(round_q(q[2], FRAC_BITS), 0, maxv));
            return res;
        endfunction

        function void note_pixel_in(pixel_t px);
            expected_pixels.push_back(adjusted_pixel(px));
        endfunction

        function void check_pixel_out(pixel_t got);
            pixel_t want;
            if (expected_pixels.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: output pixel with none expected: r=%0d g=%0d b=%0d",
                             $time, got.red, got.green, got.blue);
            end
            else begin
                want = expected_pixels.pop_front();
                if (got.red !== want.red || got.green !== want.green ||
                    got.blue !== want.blue) begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t: pixel mismatch: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                                 $time, want.red, want.green, want.blue,
                                 got.red, got.green, got.blue);
                end
            end
        endfunction

    endclass

endpackage

@@ verif/rgb_bcsh_color_adjust_test.sv @@
// Testbench top: drives pixels and settings into the color adjust block and checks outputs
module rgb_bcsh_color_adjust_test;

    timeunit 1ns;
    timeprecision 1ps;

    import bcsh_pkg::*;
    import bcsh_test_pkg::*;

    localparam int RANDOM_ITEMS = 830;
    localparam int IDLE_LIMIT   = 2000;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;
    bit               src_steady;

    bcsh_in_if  pix_in ();
    bcsh_out_if pix_out ();

    color_adjust_checker adjust_chk = new();

    rgb_bcsh_color_adjust uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_in    (pix_in),
        .pix_out   (pix_out),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // idle length: mostly short, now and then long
    function automatic int pick_gap();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 70)
            return $urandom_range(1, 2);
        else if (sel < 92)
            return $urandom_range(3, 8);
        else
            return $urandom_range(10, 40);
    endfunction

    // contrast and saturation share one range
    function automatic int pick_gain();
        case ($urandom_range(0, 5))
            0:       return 2048;
            1:       return 0;
            2:       return 4 << FRAC_BITS;
            3:       return $urandom_range(0, (1 << GAIN_W) - 1);
            default: return $urandom_range(0, 4 << FRAC_BITS);
        endcase
    endfunction

    task automatic write_reg(cfg_idx_t idx, int value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_W'(value);
        adjust_chk.set_reg(idx, CFG_W'(value));
        @(posedge clk);
    endtask

    // write all registers back to back, then let the settings settle
    task automatic configure(int mx, int cg, int bo, int ss, int lr, int lg, int hc, int hs);
        write_reg(REG_MAX_VALUE, mx);
        write_reg(REG_CONTRAST_GAIN, cg);
        write_reg(REG_BRIGHTNESS_OFFSET, bo);
        write_reg(REG_SATURATION_SCALE, ss);
        write_reg(REG_LUMA_WEIGHT_RED, lr);
        write_reg(REG_LUMA_WEIGHT_GREEN, lg);
        write_reg(REG_HUE_COSINE, hc);
        write_reg(REG_HUE_SINE, hs);
        cfg_we <= 1'b0;
        repeat (2) @(posedge clk);
    endtask

    // one item on the input channel; returns at the accepting edge
    task automatic send_pixel(int r, int g, int b);
        int     gap;
        pixel_t px;
        gap = (src_steady || $urandom_range(0, 9) < 6) ? 0 : pick_gap();
        if (gap > 0)
        begin
            pix_in.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        px.red   = PIX_W'(r);
        px.green = PIX_W'(g);
        px.blue  = PIX_W'(b);
        pix_in.valid    <= 1'b1;
        pix_in.red_in   <= px.red;
        pix_in.green_in <= px.green;
        pix_in.blue_in  <= px.blue;
        do @(posedge clk); while (!pix_in.ready);
        adjust_chk.note_pixel_in(px);
    endtask

    // drain the pipeline before the next register update
    task automatic wait_idle();
        pix_in.valid <= 1'b0;
        while (adjust_chk.pending() != 0) @(posedge clk);
        repeat (STAGES + 4) @(posedge clk);
    endtask

    // output side: random stalls, with stretches of steady ready
    initial
    begin : output_side
        int     stall_left;
        bit     steady;
        pixel_t got;
        stall_left = 0;
        steady     = 1'b0;
        pix_out.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (pix_out.valid && pix_out.ready)
            begin
                got.red   = pix_out.red_out;
                got.green = pix_out.green_out;
                got.blue  = pix_out.blue_out;
                adjust_chk.check_pixel_out(got);
            end
            if (!rst_n)
                pix_out.ready <= 1'b0;
            else if (stall_left > 0)
            begin
                pix_out.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                pix_out.ready <= 1'b1;
                if ($urandom_range(0, 199) == 0)
                    steady = !steady;
                if (!steady && $urandom_range(0, 3) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    // watchdog: ends the run when nothing moves for too long
    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // stimulus
    initial
    begin : stimulus
        int  sent, n, r, mx, bo, lr, lg, hc, hs;
        real ang;

        rst_n           <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_index       <= REG_MAX_VALUE;
        cfg_data        <= '0;
        pix_in.valid    <= 1'b0;
        pix_in.red_in   <= '0;
        pix_in.green_in <= '0;
        pix_in.blue_in  <= '0;
        src_steady       = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: neutral path, extremes and primaries
        send_pixel(0, 0, 0);
        send_pixel(1023, 1023, 1023);
        send_pixel(1023, 0, 0);
        send_pixel(0, 1023, 0);
        send_pixel(0, 0, 1023);
        send_pixel(341, 682, 513);
        wait_idle();

        // zero full scale forces black
        configure(0, 2048, 2048, 2048, 13933, 46871, 16384, 0);
        send_pixel(1023, 1023, 1023);
        send_pixel(0, 511, 1023);
        wait_idle();

        // every register but the full scale beyond its range
        configure(1023, 'h3FFF, 'h1000, 'h3FFF, 'h1FFFF, 'h1FFFF, 'h8000, 'h7FFF);
        send_pixel(1023, 512, 0);
        send_pixel(100, 900, 300);
        send_pixel(1023, 1023, 1023);
        wait_idle();

        // zero contrast, full brightness, pure gray from blue weight, quarter turn
        configure(255, 0, 2048, 0, 0, 0, 0, 16384);
        send_pixel(255, 0, 128);
        send_pixel(1023, 0, 0);
        wait_idle();

        // gains at their top, darkest offset, half turn, red-only luma
        configure(1023, 8192, -2048, 8192, 65536, 0, -16384, 0);
        send_pixel(1023, 0, 512);
        send_pixel(800, 900, 1000);
        wait_idle();

        // cosine one but sine not zero: rotation must run
        configure(1023, 3000, 300, 5000, 13933, 46871, 16384, -16384);
        send_pixel(1023, 0, 700);
        send_pixel(3, 1020, 511);
        wait_idle();

        // sine zero, cosine just below one, one-step full scale
        configure(1, 2048, 0, 0, 13933, 46871, 16383, 0);
        send_pixel(1, 0, 1);
        send_pixel(0, 1, 0);
        wait_idle();

        // top raw codes for brightness and angles
        configure(1023, 2048, 'h0FFF, 2048, 13933, 46871, 'h7FFF, 'h8000);
        send_pixel(0, 0, 0);
        send_pixel(600, 200, 900);
        wait_idle();

        // random settings, each followed by a burst of random pixels
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 9))
                0:       mx = 1023;
                1:       mx = 255;
                2:       mx = 1;
                3:       mx = ($urandom_range(0, 3) == 0) ? 0 : 1023;
                default: mx = $urandom_range(1, 1023);
            endcase
            case ($urandom_range(0, 5))
                0:       bo = 0;
                1:       bo = 2048;
                2:       bo = -2048;
                3:       bo = $urandom_range(0, (1 << BRI_W) - 1);
                default: bo = $urandom_range(0, 4096) - 2048;
            endcase
            case ($urandom_range(0, 5))
                0:
                begin
                    lr = 13933;
                    lg = 46871;
                end
                1:
                begin
                    lr = 0;
                    lg = 0;
                end
                2:
                begin
                    lr = 65536;
                    lg = $urandom_range(0, 65536);
                end
                3:
                begin
                    lr = $urandom_range(0, (1 << WGT_W) - 1);
                    lg = $urandom_range(0, (1 << WGT_W) - 1);
                end
                default:
                begin
                    lr = $urandom_range(0, 65536);
                    lg = $urandom_range(0, 65536 - lr);
                end
            endcase
            case ($urandom_range(0, 7))
                0, 1:
                begin
                    hc = 16384;
                    hs = 0;
                end
                2:
                begin
                    hc = $urandom_range(0, (1 << ANG_W) - 1);
                    hs = $urandom_range(0, (1 << ANG_W) - 1);
                end
                3:
                begin
                    hc = $urandom_range(0, 32768) - 16384;
                    hs = $urandom_range(0, 32768) - 16384;
                end
                default:
                begin
                    ang = $urandom_range(0, 359) * 3.14159265358979 / 180.0;
                    hc  = $rtoi($cos(ang) * 16384.0);
                    hs  = $rtoi($sin(ang) * 16384.0);
                end
            endcase
            configure(mx, pick_gain(), bo, pick_gain(), lr, lg, hc, hs);

            n          = $urandom_range(20, 100);
            src_steady = ($urandom_range(0, 3) == 0);
            repeat (n)
            begin
                case ($urandom_range(0, 9))
                    0:
                        send_pixel($urandom_range(0, 1) * 1023, $urandom_range(0, 1) * 1023,
                                   $urandom_range(0, 1) * 1023);
                    1:
                    begin
                        r = $urandom_range(0, 1023);
                        send_pixel(r, r, r);
                    end
                    default:
                        send_pixel($urandom_range(0, 1023), $urandom_range(0, 1023),
                                   $urandom_range(0, 1023));
                endcase
            end
            sent += n;
            wait_idle();
        end

        if (adjust_chk.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
